// ===== rtl/core/pogp_pkg.sv =====
`timescale 1ns / 1ps
package pogp_pkg;

  // Field widths.
  localparam int TOK_W = 3;
  localparam int LEN_W = 16;
  localparam int ANG_W = 15;
  localparam int NECK_W = 14;
  localparam int SUM_W = 17;
  localparam int WRAP_W = 18;
  localparam int TURN_W = 15;

  // Angle format: one degree is 64 units, a full turn 360 degrees.
  localparam int FULL_TURN = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int THREE_QUARTER_TURN = 17280;

  // Turning m into 2^-32 of a turn: floor(m * 2^23 / 45), taken as
  // quotient and remainder by 45 and a remainder term.
  localparam int DIV_K = 45;
  localparam int DIV_RECIP = 1457;
  localparam int RECIP_SHIFT = 16;
  localparam int BA_SHIFT = 23;
  localparam int BA_UNIT = 186413;
  localparam int BA_FRAC_NUM = 23;
  localparam int QUOT_W = 10;
  localparam int REM_W = 6;
  localparam int BA_W = 32;

  // Shared multiplier and accumulation widths.
  localparam int MUL_W = 34;
  localparam int PROD_W = 68;
  localparam int WIDE_W = 70;
  localparam int POS_SHIFT = 30;
  localparam int VEL_SHIFT = 38;
  localparam int RATE_SHIFT = 8;

  // Rotator.
  localparam int CORDIC_ITER = 16;
  localparam int CNT_W = 5;
  localparam int IDX_W = 4;
  localparam logic signed [MUL_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] PI_OVER_180 = 34'sd74961321;
  localparam logic signed [MUL_W-1:0] HALF_TURN_Z = 34'sd2147483648;
  localparam logic signed [MUL_W-1:0] QUARTER_Z = 34'sd1073741824;

  localparam logic [LEN_W-1:0] DIST_RESET = 16'd25600;

  // Token counts that carry new values.
  localparam logic [TOK_W-1:0] TOK_FULL = 3'd4;
  localparam logic [TOK_W-1:0] TOK_POLAR = 3'd2;
  localparam logic [TOK_W-1:0] TOK_DIR = 3'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRAP, ST_QUOT, ST_TURN, ST_TRIG, ST_ISSUE, ST_TAKE, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_GX, OP_GY, OP_P, OP_K, OP_DRC, OP_KS, OP_DRS, OP_KC
  } mul_op_t;

  // Arctangent of 2^-i in 2^-32 of a turn.
  function automatic logic signed [MUL_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
    logic signed [MUL_W-1:0] v;
    v = '0;
    unique case (idx)
      4'd0: v = 34'sh20000000;
      4'd1: v = 34'sh12E4051E;
      4'd2: v = 34'sh09FB385B;
      4'd3: v = 34'sh051111D4;
      4'd4: v = 34'sh028B0D43;
      4'd5: v = 34'sh0145D7E1;
      4'd6: v = 34'sh00A2F61E;
      4'd7: v = 34'sh00517C55;
      4'd8: v = 34'sh0028BE53;
      4'd9: v = 34'sh00145F2F;
      4'd10: v = 34'sh000A2F98;
      4'd11: v = 34'sh000517CC;
      4'd12: v = 34'sh00028BE6;
      4'd13: v = 34'sh000145F3;
      4'd14: v = 34'sh0000A2FA;
      4'd15: v = 34'sh0000517D;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Add half an LSB and shift right arithmetically.
  function automatic logic signed [WIDE_W-1:0] round_sh(input logic signed [WIDE_W-1:0] v,
                                                        input int s);
    logic signed [WIDE_W-1:0] half;
    half = '0;
    half[s-1] = 1'b1;
    return (v + half) >>> s;
  endfunction

  // Clamp to the 16-bit signed range.
  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > 70'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -70'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pogp_if.sv =====
`timescale 1ns / 1ps
interface pogp_in_if;
  logic valid;
  logic ready;
  logic [2:0] token_count;
  logic [15:0] obs_distance;
  logic signed [14:0] obs_direction;
  logic signed [15:0] obs_dist_rate;
  logic signed [15:0] obs_dir_rate;
  logic signed [15:0] observer_x;
  logic signed [15:0] observer_y;
  logic signed [14:0] observer_body;
  logic signed [13:0] observer_neck;
  logic signed [15:0] observer_vx;
  logic signed [15:0] observer_vy;

  modport source (output valid, token_count, obs_distance, obs_direction, obs_dist_rate,
                  obs_dir_rate, observer_x, observer_y, observer_body, observer_neck,
                  observer_vx, observer_vy, input ready);
  modport sink (input valid, token_count, obs_distance, obs_direction, obs_dist_rate,
                obs_dir_rate, observer_x, observer_y, observer_body, observer_neck,
                observer_vx, observer_vy, output ready);
endinterface

interface pogp_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] global_x;
  logic signed [15:0] global_y;
  logic signed [15:0] global_vx;
  logic signed [15:0] global_vy;
  logic localized;
  logic velocity_fault;

  modport source (output valid, global_x, global_y, global_vx, global_vy, localized,
                  velocity_fault, input ready);
  modport sink (input valid, global_x, global_y, global_vx, global_vy, localized,
                velocity_fault, output ready);
endinterface

// ===== rtl/core/polar_observation_to_global_position_unit.sv =====
`timescale 1ns / 1ps
// Turns one polar observation into a global position and, for a full four-value
// observation, a global velocity. The block takes no new request until its
// result has been loaded into the output register. Cosine and sine come from
// the 16-step shift-and-add rotator, and the single registered multiplier
// serves two position products and six velocity products in turn.
module polar_observation_to_global_position_unit (
  input logic clk,
  input logic rst_n,
  pogp_in_if.sink in_ch,
  pogp_out_if.source out_ch
);
  import pogp_pkg::*;

  state_t state_r, state_nxt;
  mul_op_t op_r, op_nxt;

  // Kept observation state.
  logic [LEN_W-1:0] last_dist_r;
  logic signed [ANG_W-1:0] last_dir_r;
  logic signed [15:0] last_drate_r, last_arate_r;
  logic signed [15:0] held_vx_r, held_vy_r;

  // Per-request working registers.
  logic [TOK_W-1:0] tok_r;
  logic signed [15:0] ox_r, oy_r, ovx_r, ovy_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [TURN_W-1:0] m_r;
  logic [QUOT_W-1:0] q_r;
  logic [REM_W-1:0] rem_r;
  logic flip_r, vel_en_r, fault_r;
  logic signed [MUL_W-1:0] c_r, s_r, pk_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [15:0] gx_r, gy_r;

  // Output register.
  logic out_valid_r;
  logic signed [15:0] o_gx_r, o_gy_r, o_vx_r, o_vy_r;
  logic o_loc_r, o_fault_r;

  logic accept, load_out;
  logic cordic_start, cordic_done;
  logic signed [MUL_W-1:0] cx, cy, z0;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_GX;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cordic_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: state_nxt = ST_QUOT;
      ST_QUOT: state_nxt = ST_TURN;
      ST_TURN: begin
        cordic_start = 1'b1;
        state_nxt = ST_TRIG;
      end
      ST_TRIG: begin
        if (cordic_done) begin
          state_nxt = ST_ISSUE;
          op_nxt = OP_GX;
        end
      end
      ST_ISSUE: state_nxt = ST_TAKE;
      ST_TAKE: begin
        state_nxt = ST_ISSUE;
        if (op_r == OP_KC || (op_r == OP_GY && !vel_en_r)) begin
          state_nxt = ST_DONE;
        end else begin
          op_nxt = mul_op_t'(op_r + 3'd1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Stored values, updated by the tokens present in the request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dist_r <= DIST_RESET;
      last_dir_r <= '0;
      last_drate_r <= '0;
      last_arate_r <= '0;
    end else if (accept) begin
      case (in_ch.token_count)
        TOK_FULL: begin
          last_dist_r <= in_ch.obs_distance;
          last_dir_r <= in_ch.obs_direction;
          last_drate_r <= in_ch.obs_dist_rate;
          last_arate_r <= in_ch.obs_dir_rate;
        end
        TOK_POLAR: begin
          last_dist_r <= in_ch.obs_distance;
          last_dir_r <= in_ch.obs_direction;
        end
        TOK_DIR: last_dir_r <= in_ch.obs_direction;
        default: ;
      endcase
    end
  end

  // Absolute angle sum, using the new direction where one is present.
  logic signed [ANG_W-1:0] dir_sel;
  always_comb begin
    case (in_ch.token_count) inside
      TOK_FULL, TOK_POLAR, TOK_DIR: dir_sel = in_ch.obs_direction;
      default: dir_sel = last_dir_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_r <= in_ch.token_count;
      ox_r <= in_ch.observer_x;
      oy_r <= in_ch.observer_y;
      ovx_r <= in_ch.observer_vx;
      ovy_r <= in_ch.observer_vy;
      sum_r <= SUM_W'(in_ch.observer_body) + SUM_W'(in_ch.observer_neck) + SUM_W'(dir_sel);
    end
  end

  // Reduction of the angle sum into one turn.
  logic signed [WRAP_W-1:0] sum_x, wrap_up1, wrap_up2, wrap_dn, wrap_sel;
  always_comb begin
    sum_x = WRAP_W'(sum_r);
    wrap_up1 = sum_x + WRAP_W'(FULL_TURN);
    wrap_up2 = sum_x + WRAP_W'(2 * FULL_TURN);
    wrap_dn = sum_x - WRAP_W'(FULL_TURN);
    if (sum_x < 0) begin
      wrap_sel = (wrap_up1 < 0) ? wrap_up2 : wrap_up1;
    end else if (sum_x >= WRAP_W'(FULL_TURN)) begin
      wrap_sel = wrap_dn;
    end else begin
      wrap_sel = sum_x;
    end
  end

  // Quotient and remainder of the turn by 45, by reciprocal and one correction.
  logic [25:0] q_prod;
  logic [QUOT_W-1:0] q_est;
  logic signed [16:0] rem_est;
  always_comb begin
    q_prod = 26'(m_r) * 26'(DIV_RECIP);
    q_est = q_prod[RECIP_SHIFT +: QUOT_W];
    rem_est = 17'(m_r) - 17'(q_est) * 17'(DIV_K);
  end

  // Angle as 2^-32 of a turn, then folded into the right half plane.
  logic [BA_W-1:0] ba;
  logic [15:0] frac_num;
  logic [26:0] frac_prod;
  logic signed [MUL_W-1:0] z_raw;
  always_comb begin
    frac_num = 16'(rem_r) * 16'(BA_FRAC_NUM);
    frac_prod = 27'(frac_num) * 27'(DIV_RECIP);
    ba = {q_r[8:0], {BA_SHIFT{1'b0}}} + BA_W'(rem_r) * BA_W'(BA_UNIT)
         + BA_W'(frac_prod[26:RECIP_SHIFT]);
    z_raw = MUL_W'($signed(ba));
    if (z_raw > QUARTER_Z) begin
      z0 = z_raw - HALF_TURN_Z;
    end else if (z_raw < -QUARTER_Z) begin
      z0 = z_raw + HALF_TURN_Z;
    end else begin
      z0 = z_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WRAP) begin
      m_r <= wrap_sel[TURN_W-1:0];
    end
    if (state_r == ST_QUOT) begin
      if (rem_est < 0) begin
        q_r <= q_est - 1'b1;
        rem_r <= REM_W'(rem_est + 17'sd45);
      end else begin
        q_r <= q_est;
        rem_r <= rem_est[REM_W-1:0];
      end
      fault_r <= (tok_r == TOK_FULL) && (last_dist_r == '0 ||
                 m_r == TURN_W'(QUARTER_TURN) || m_r == TURN_W'(THREE_QUARTER_TURN));
      vel_en_r <= (tok_r == TOK_FULL) && !(last_dist_r == '0 ||
                  m_r == TURN_W'(QUARTER_TURN) || m_r == TURN_W'(THREE_QUARTER_TURN));
    end
    if (state_r == ST_TURN) begin
      flip_r <= (z_raw > QUARTER_Z) || (z_raw < -QUARTER_Z);
    end
    if (state_r == ST_TRIG && cordic_done) begin
      c_r <= flip_r ? -cx : cx;
      s_r <= flip_r ? -cy : cy;
    end
  end

  pogp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .z0    (z0),
    .done  (cordic_done),
    .x_out (cx),
    .y_out (cy)
  );

  // Operand selection for the shared multiplier.
  logic signed [MUL_W-1:0] dist_op, drq_op, arate_op;
  always_comb begin
    dist_op = MUL_W'($signed({1'b0, last_dist_r}));
    drq_op = {{(MUL_W-16-RATE_SHIFT){last_drate_r[15]}}, last_drate_r, {RATE_SHIFT{1'b0}}};
    arate_op = MUL_W'(last_arate_r);
    unique case (op_r)
      OP_GX: begin mul_a = c_r; mul_b = dist_op; end
      OP_GY: begin mul_a = s_r; mul_b = dist_op; end
      OP_P: begin mul_a = arate_op; mul_b = dist_op; end
      OP_K: begin mul_a = pk_r; mul_b = PI_OVER_180; end
      OP_DRC: begin mul_a = drq_op; mul_b = c_r; end
      OP_KS: begin mul_a = pk_r; mul_b = s_r; end
      OP_DRS: begin mul_a = drq_op; mul_b = s_r; end
      OP_KC: begin mul_a = pk_r; mul_b = c_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  pogp_mul u_mul (
    .clk (clk),
    .en  (state_r == ST_ISSUE),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Use of each product.
  logic signed [WIDE_W-1:0] prod_w, acc_w;
  assign prod_w = WIDE_W'(prod);
  assign acc_w = WIDE_W'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vx_r <= '0;
      held_vy_r <= '0;
    end else if (state_r == ST_TAKE) begin
      if (op_r == OP_KS) begin
        held_vx_r <= sat16(WIDE_W'(ovx_r) + round_sh(acc_w - prod_w, VEL_SHIFT));
      end
      if (op_r == OP_KC) begin
        held_vy_r <= sat16(WIDE_W'(ovy_r) + round_sh(acc_w + prod_w, VEL_SHIFT));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TAKE) begin
      case (op_r) inside
        OP_GX: gx_r <= sat16(WIDE_W'(ox_r) + round_sh(prod_w, POS_SHIFT));
        OP_GY: gy_r <= sat16(WIDE_W'(oy_r) + round_sh(prod_w, POS_SHIFT));
        OP_P: pk_r <= prod[MUL_W-1:0];
        OP_K: pk_r <= MUL_W'(round_sh(prod_w, POS_SHIFT));
        OP_DRC, OP_DRS: acc_r <= prod;
        default: ;
      endcase
    end
  end

  // Output register: loaded once the sequence ends and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_gx_r <= gx_r;
      o_gy_r <= gy_r;
      o_vx_r <= held_vx_r;
      o_vy_r <= held_vy_r;
      o_loc_r <= vel_en_r;
      o_fault_r <= fault_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.global_x = o_gx_r;
  assign out_ch.global_y = o_gy_r;
  assign out_ch.global_vx = o_vx_r;
  assign out_ch.global_vy = o_vy_r;
  assign out_ch.localized = o_loc_r;
  assign out_ch.velocity_fault = o_fault_r;

endmodule

// ===== rtl/core/pogp_cordic.sv =====
`timescale 1ns / 1ps
module pogp_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [pogp_pkg::MUL_W-1:0] z0,
  output logic                             done,
  output logic signed [pogp_pkg::MUL_W-1:0] x_out,
  output logic signed [pogp_pkg::MUL_W-1:0] y_out
);
  import pogp_pkg::*;

  logic signed [MUL_W-1:0] x_r, y_r, z_r;
  logic signed [MUL_W-1:0] x_nxt, y_nxt, z_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic run_r, done_r;
  logic [IDX_W-1:0] idx;

  assign idx = cnt_r[IDX_W-1:0];

  // One rotation step, direction chosen by the sign of the residual angle.
  always_comb begin
    if (z_r >= 0) begin
      x_nxt = x_r - (y_r >>> idx);
      y_nxt = y_r + (x_r >>> idx);
      z_nxt = z_r - atan_turn(idx);
    end else begin
      x_nxt = x_r + (y_r >>> idx);
      y_nxt = y_r - (x_r >>> idx);
      z_nxt = z_r + atan_turn(idx);
    end
  end

  // Iteration counter and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_ITER - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Vector and angle registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_START;
      y_r <= '0;
      z_r <= z0;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

// ===== rtl/core/pogp_mul.sv =====
`timescale 1ns / 1ps
module pogp_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [pogp_pkg::MUL_W-1:0]  a,
  input  logic signed [pogp_pkg::MUL_W-1:0]  b,
  output logic signed [pogp_pkg::PROD_W-1:0] p
);
  import pogp_pkg::*;

  logic signed [PROD_W-1:0] p_r;

  // Signed product, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/core/pogp_checker.sv =====
`timescale 1ns / 1ps
module pogp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] out_gx,
  input logic out_loc,
  input logic out_fault
);

  // A result waiting to be taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A waiting result keeps its x position value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_gx))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // A velocity solve either succeeds or faults, never both.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_loc && out_fault))
    else $error("localized and fault both set");

endmodule

bind polar_observation_to_global_position_unit pogp_checker u_pogp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_gx    (out_ch.global_x),
  .out_loc   (out_ch.localized),
  .out_fault (out_ch.velocity_fault)
);
